@@ rtl/vtgd_pkg.sv @@
// ---------------------------------------------------------------------------
// vtgd_pkg
// Shared types, codes and helpers of the vector tile geometry decoder.
// ---------------------------------------------------------------------------
package vtgd_pkg;

    // Feature length bound: a command whose words would reach this overruns
    localparam int unsigned MAX_WORDS = 65536;

    // Decoded-vertex queue between front and back (power of two)
    localparam int unsigned QDEPTH  = 4;
    localparam int unsigned QPTR_W  = $clog2(QDEPTH);
    localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

    // Command ids (low 3 bits of a command word)
    localparam logic [2:0] CMD_MOVE_TO    = 3'd1;
    localparam logic [2:0] CMD_LINE_TO    = 3'd2;
    localparam logic [2:0] CMD_CLOSE_PATH = 3'd7;

    // Feature geometry types
    localparam logic [1:0] GEOM_POLYGON = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_X_ORIGIN = 2'd0;
    localparam logic [1:0] CFG_Y_ORIGIN = 2'd1;
    localparam logic [1:0] CFG_X_STEP   = 2'd2;
    localparam logic [1:0] CFG_Y_STEP   = 2'd3;

    localparam logic [47:0] STEP_RESET = 48'h0001_0000_0000;

    // Decoder phase
    typedef enum logic [1:0] {
        PH_CMD = 2'd0,
        PH_DX  = 2'd1,
        PH_DY  = 2'd2
    } t_phase;

    // Result kinds
    typedef enum logic [2:0] {
        K_START       = 3'd0,
        K_VERTEX      = 3'd1,
        K_RING_CLOSE  = 3'd2,
        K_MALFORMED   = 3'd3,
        K_FEATURE_END = 3'd4
    } t_kind;

    // One decoded result before map scaling
    typedef struct packed {
        t_kind              kind;
        logic signed [31:0] tile_x;
        logic signed [31:0] tile_y;
        logic               feature_end;
    } t_rec;

    // Front to queue
    typedef struct packed {
        logic valid;
        t_rec rec;
    } t_qpush;

    // Map transform registers
    typedef struct packed {
        logic [63:0] x_origin;
        logic [63:0] y_origin;
        logic [47:0] x_step;
        logic [47:0] y_step;
    } t_cfg;

    // Zigzag decode, logical shift
    function automatic logic [31:0] unzig(input logic [31:0] w);
        return {1'b0, w[31:1]} ^ {32{w[0]}};
    endfunction

endpackage

@@ rtl/vtgd_front.sv @@
// ---------------------------------------------------------------------------
// vtgd_front
// Command/parameter decoder: tracks phase, cursor and ring, and emits at
// most one tile-unit result per accepted word.
// ---------------------------------------------------------------------------
module vtgd_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [31:0]      i_word,
    input  logic [1:0]       i_geom_kind,
    input  logic [15:0]      i_words_after,
    output vtgd_pkg::t_qpush o_push
);
    import vtgd_pkg::*;

    localparam logic [29:0] MAX_WORDS_W = 30'(MAX_WORDS);

    t_phase      r_phase, n_phase;
    logic [15:0] r_pairs_left, n_pairs_left;
    logic        r_is_line, n_is_line;
    logic [31:0] r_held_dx, n_held_dx;
    logic [31:0] r_cursor_x, n_cursor_x;
    logic [31:0] r_cursor_y, n_cursor_y;
    logic        r_skipping, n_skipping;
    logic        r_ring_open, n_ring_open;
    logic [31:0] r_ring_x, n_ring_x;
    logic [31:0] r_ring_y, n_ring_y;

    logic [2:0]  w_id;
    logic [28:0] w_cnt;
    logic [29:0] w_cnt2;
    logic        w_last;
    logic        w_move_line;
    logic        w_overrun;
    logic        w_close_ok;

    // Word decode
    assign w_id        = i_word[2:0];
    assign w_cnt       = i_word[31:3];
    assign w_cnt2      = {w_cnt, 1'b0};
    assign w_last      = (i_words_after == 16'd0);
    assign w_move_line = (w_id == CMD_MOVE_TO) || (w_id == CMD_LINE_TO);
    assign w_overrun   = (w_cnt2 > {14'd0, i_words_after}) || (w_cnt2 >= MAX_WORDS_W);
    assign w_close_ok  = (w_id == CMD_CLOSE_PATH) && (i_geom_kind == GEOM_POLYGON)
                         && r_ring_open;

    // Datapath and result
    always_comb begin
        n_pairs_left = r_pairs_left;
        n_is_line    = r_is_line;
        n_held_dx    = r_held_dx;
        n_cursor_x   = r_cursor_x;
        n_cursor_y   = r_cursor_y;
        n_skipping   = r_skipping;
        n_ring_open  = r_ring_open;
        n_ring_x     = r_ring_x;
        n_ring_y     = r_ring_y;
        o_push.valid           = 1'b0;
        o_push.rec.kind        = K_FEATURE_END;
        o_push.rec.tile_x      = r_cursor_x;
        o_push.rec.tile_y      = r_cursor_y;
        o_push.rec.feature_end = w_last;
        if (i_accept) begin
            if (!r_skipping) begin
                case (r_phase)
                    PH_DX: begin
                        n_held_dx = unzig(i_word);
                    end
                    PH_DY: begin
                        n_cursor_x = r_cursor_x + r_held_dx;
                        n_cursor_y = r_cursor_y + unzig(i_word);
                        if (!r_ring_open) begin
                            n_ring_open = 1'b1;
                            n_ring_x    = n_cursor_x;
                            n_ring_y    = n_cursor_y;
                        end
                        o_push.valid      = 1'b1;
                        o_push.rec.kind   = r_is_line ? K_VERTEX : K_START;
                        o_push.rec.tile_x = n_cursor_x;
                        o_push.rec.tile_y = n_cursor_y;
                        n_pairs_left = (r_pairs_left != 16'd0) ? r_pairs_left - 16'd1 : 16'd0;
                    end
                    default: begin
                        if (w_move_line) begin
                            if (w_overrun) begin
                                o_push.valid    = 1'b1;
                                o_push.rec.kind = K_MALFORMED;
                                n_skipping      = 1'b1;
                            end else if (w_cnt != 29'd0) begin
                                // overrun check bounds the count to 16 bits
                                n_pairs_left = w_cnt[15:0];
                                n_is_line    = (w_id == CMD_LINE_TO);
                            end
                        end else if (w_close_ok) begin
                            o_push.valid      = 1'b1;
                            o_push.rec.kind   = K_RING_CLOSE;
                            o_push.rec.tile_x = r_ring_x;
                            o_push.rec.tile_y = r_ring_y;
                            n_ring_open       = 1'b0;
                        end
                    end
                endcase
            end
            // Last word: always one result, then clear the feature state
            if (w_last) begin
                o_push.valid = 1'b1;
                n_pairs_left = '0;
                n_is_line    = 1'b0;
                n_held_dx    = '0;
                n_cursor_x   = '0;
                n_cursor_y   = '0;
                n_skipping   = 1'b0;
                n_ring_open  = 1'b0;
                n_ring_x     = '0;
                n_ring_y     = '0;
            end
        end
    end

    // Next phase
    always_comb begin
        n_phase = r_phase;
        if (i_accept) begin
            if (w_last) begin
                n_phase = PH_CMD;
            end else if (!r_skipping) begin
                case (r_phase)
                    PH_DX:   n_phase = PH_DY;
                    PH_DY:   n_phase = (n_pairs_left == 16'd0) ? PH_CMD : PH_DX;
                    default: begin
                        if (w_move_line && !w_overrun && (w_cnt != 29'd0)) begin
                            n_phase = PH_DX;
                        end else begin
                            n_phase = PH_CMD;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_CMD;
            r_pairs_left <= '0;
            r_is_line    <= 1'b0;
            r_held_dx    <= '0;
            r_cursor_x   <= '0;
            r_cursor_y   <= '0;
            r_skipping   <= 1'b0;
            r_ring_open  <= 1'b0;
            r_ring_x     <= '0;
            r_ring_y     <= '0;
        end else begin
            r_phase      <= n_phase;
            r_pairs_left <= n_pairs_left;
            r_is_line    <= n_is_line;
            r_held_dx    <= n_held_dx;
            r_cursor_x   <= n_cursor_x;
            r_cursor_y   <= n_cursor_y;
            r_skipping   <= n_skipping;
            r_ring_open  <= n_ring_open;
            r_ring_x     <= n_ring_x;
            r_ring_y     <= n_ring_y;
        end
    end

    // A malformed feature waits for its end in the command phase
    a_skip_in_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skipping |-> (r_phase == PH_CMD))
        else $error("skipping outside command phase");

    // Feature end clears cursor, skip and ring
    a_feature_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && w_last) |=> (r_cursor_x == 32'd0) && (r_cursor_y == 32'd0)
                                 && !r_skipping && !r_ring_open && (r_phase == PH_CMD))
        else $error("feature state not cleared after last word");

endmodule

@@ rtl/vtgd_queue.sv @@
// ---------------------------------------------------------------------------
// vtgd_queue
// Small register queue of decoded results between front and back.
// ---------------------------------------------------------------------------
module vtgd_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  vtgd_pkg::t_qpush i_push,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_nonempty,
    output vtgd_pkg::t_rec   o_head
);
    import vtgd_pkg::*;

    localparam logic [QCNT_W-1:0] DEPTH_C = QCNT_W'(QDEPTH);

    t_rec              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;
    logic              w_do_push;
    logic              w_do_pop;

    assign o_full     = (r_count == DEPTH_C);
    assign o_nonempty = (r_count != '0);
    assign o_head     = r_mem[r_rd_ptr];
    assign w_do_push  = i_push.valid;
    assign w_do_pop   = i_pop && o_nonempty;

    // Pointer and fill bookkeeping
    always_comb begin
        n_wr_ptr = w_do_push ? r_wr_ptr + QPTR_W'(1) : r_wr_ptr;
        n_rd_ptr = w_do_pop  ? r_rd_ptr + QPTR_W'(1) : r_rd_ptr;
        n_count  = r_count;
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (!w_do_push && w_do_pop) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_push.rec;
        end
    end

    // Front only pushes while there is room
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.valid |-> !o_full)
        else $error("push into full queue");

endmodule

@@ rtl/vtgd_back.sv @@
// ---------------------------------------------------------------------------
// vtgd_back
// Map-coordinate pipeline: magnitude, split 48x32 multiply, Q.16 align,
// origin add with sign, then the output register. Each stage holds on stall.
// ---------------------------------------------------------------------------
module vtgd_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  vtgd_pkg::t_cfg i_cfg,
    input  logic           i_in_valid,
    input  vtgd_pkg::t_rec i_in_rec,
    output logic           o_in_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output vtgd_pkg::t_rec o_rec,
    output logic [63:0]    o_map_x,
    output logic [63:0]    o_map_y
);
    import vtgd_pkg::*;

    // stage 1: magnitude and sign
    logic        r_s1_valid;
    t_rec        r_s1_rec;
    logic [31:0] r_s1_mx, r_s1_my;
    logic        r_s1_nx, r_s1_ny;
    // stage 2: partial products
    logic        r_s2_valid;
    t_rec        r_s2_rec;
    logic        r_s2_nx, r_s2_ny;
    logic [55:0] r_s2_pxh, r_s2_pxl, r_s2_pyh, r_s2_pyl;
    // stage 3: scaled magnitude
    logic        r_s3_valid;
    t_rec        r_s3_rec;
    logic        r_s3_nx, r_s3_ny;
    logic [63:0] r_s3_qx, r_s3_qy;
    // stage 4: output register
    logic        r_s4_valid;
    t_rec        r_s4_rec;
    logic [63:0] r_s4_map_x, r_s4_map_y;

    logic        w_en1, w_en2, w_en3, w_en4;
    logic [31:0] w_tx, w_ty;

    // Stall chain
    assign w_en4    = !r_s4_valid || i_ready;
    assign w_en3    = !r_s3_valid || w_en4;
    assign w_en2    = !r_s2_valid || w_en3;
    assign w_en1    = !r_s1_valid || w_en2;
    assign o_in_pop = i_in_valid && w_en1;

    assign w_tx = i_in_rec.tile_x;
    assign w_ty = i_in_rec.tile_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else begin
            if (w_en1) r_s1_valid <= i_in_valid;
            if (w_en2) r_s2_valid <= r_s1_valid;
            if (w_en3) r_s3_valid <= r_s2_valid;
            if (w_en4) r_s4_valid <= r_s3_valid;
        end
    end

    // Stage 1: absolute tile coordinates
    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_s1_rec <= i_in_rec;
            r_s1_nx  <= w_tx[31];
            r_s1_ny  <= w_ty[31];
            r_s1_mx  <= w_tx[31] ? (~w_tx + 32'd1) : w_tx;
            r_s1_my  <= w_ty[31] ? (~w_ty + 32'd1) : w_ty;
        end
    end

    // Stage 2: step split into two 24-bit halves, 32x24 products
    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r_s2_rec <= r_s1_rec;
            r_s2_nx  <= r_s1_nx;
            r_s2_ny  <= r_s1_ny;
            r_s2_pxh <= r_s1_mx * i_cfg.x_step[47:24];
            r_s2_pxl <= r_s1_mx * i_cfg.x_step[23:0];
            r_s2_pyh <= r_s1_my * i_cfg.y_step[47:24];
            r_s2_pyl <= r_s1_my * i_cfg.y_step[23:0];
        end
    end

    // Stage 3: Q.32 product down to Q.16, truncated
    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r_s3_rec <= r_s2_rec;
            r_s3_nx  <= r_s2_nx;
            r_s3_ny  <= r_s2_ny;
            r_s3_qx  <= {r_s2_pxh, 8'd0} + {24'd0, r_s2_pxl[55:16]};
            r_s3_qy  <= {r_s2_pyh, 8'd0} + {24'd0, r_s2_pyl[55:16]};
        end
    end

    // Stage 4: origin plus or minus the scaled magnitude (y axis points south)
    always_ff @(posedge i_clk) begin
        if (w_en4) begin
            r_s4_rec   <= r_s3_rec;
            r_s4_map_x <= r_s3_nx ? (i_cfg.x_origin - r_s3_qx) : (i_cfg.x_origin + r_s3_qx);
            r_s4_map_y <= r_s3_ny ? (i_cfg.y_origin + r_s3_qy) : (i_cfg.y_origin - r_s3_qy);
        end
    end

    assign o_valid = r_s4_valid;
    assign o_rec   = r_s4_rec;
    assign o_map_x = r_s4_map_x;
    assign o_map_y = r_s4_map_y;

endmodule

@@ rtl/vector_tile_geometry_decoder_core.sv @@
// ---------------------------------------------------------------------------
// vector_tile_geometry_decoder_core
// Throughput: one word per cycle while the queue has room; the front decoder pushes
// at most one result per word, and the 4-stage map pipeline behind a 4-entry queue
// takes one per cycle unless the result output stalls it.
// Reset (synchronous, active low) clears decoder state, queue and pipeline,
// and loads origins 0 and steps 1.0; no clearing pass is needed.
// ---------------------------------------------------------------------------
module vector_tile_geometry_decoder_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // input words
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    input  logic [47:0]   i_s_axis_tdata,   // [31:0] word, [47:32] words_after
    input  logic [1:0]    i_s_axis_tuser,   // [1:0] geom_kind
    // results
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    output logic [191:0]  o_m_axis_tdata,   // [31:0] tile_x, [63:32] tile_y,
                                            // [127:64] map_x, [191:128] map_y
    output logic [2:0]    o_m_axis_tuser,   // [2:0] kind
    output logic          o_m_axis_tlast,   // feature_end
    // configuration
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [63:0]   i_cfg_data
);
    import vtgd_pkg::*;

    t_cfg        r_cfg;
    t_qpush      w_push;
    logic        w_accept;
    logic        w_q_full;
    logic        w_q_nonempty;
    logic        w_q_pop;
    t_rec        w_q_head;
    t_rec        w_out_rec;
    logic [63:0] w_map_x, w_map_y;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.x_origin <= '0;
            r_cfg.y_origin <= '0;
            r_cfg.x_step   <= STEP_RESET;
            r_cfg.y_step   <= STEP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_X_ORIGIN: r_cfg.x_origin <= i_cfg_data;
                CFG_Y_ORIGIN: r_cfg.y_origin <= i_cfg_data;
                CFG_X_STEP:   r_cfg.x_step   <= i_cfg_data[47:0];
                CFG_Y_STEP:   r_cfg.y_step   <= i_cfg_data[47:0];
                default: ;
            endcase
        end
    end

    assign o_s_axis_tready = !w_q_full;
    assign w_accept        = i_s_axis_tvalid && !w_q_full;

    vtgd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_word        (i_s_axis_tdata[31:0]),
        .i_geom_kind   (i_s_axis_tuser),
        .i_words_after (i_s_axis_tdata[47:32]),
        .o_push        (w_push)
    );

    vtgd_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_pop      (w_q_pop),
        .o_full     (w_q_full),
        .o_nonempty (w_q_nonempty),
        .o_head     (w_q_head)
    );

    vtgd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (w_q_nonempty),
        .i_in_rec   (w_q_head),
        .o_in_pop   (w_q_pop),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_rec      (w_out_rec),
        .o_map_x    (w_map_x),
        .o_map_y    (w_map_y)
    );

    // Result packing
    assign o_m_axis_tdata = {w_map_y, w_map_x, w_out_rec.tile_y, w_out_rec.tile_x};
    assign o_m_axis_tuser = w_out_rec.kind;
    assign o_m_axis_tlast = w_out_rec.feature_end;

endmodule
